// ===== rtl/trs_pkg.sv =====
// Package for the pose to model matrix builder: types, constants and helpers.
package trs_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int IN_DATA_W  = 240;
  localparam int OUT_DATA_W = 384;

  typedef logic signed [33:0] cval_t;  // CORDIC x or y, Q2.30 with headroom
  typedef logic signed [32:0] zval_t;  // angle, Q3.28 with headroom

  localparam zval_t PI_Q28      = 33'sd843314857;
  localparam zval_t TWO_PI_Q28  = 33'sd1686629713;
  localparam zval_t HALF_PI_Q28 = 33'sd421657428;
  localparam cval_t GAIN_Q30    = 34'sd652032874;

  typedef struct packed {
    cval_t x;
    cval_t y;
    zval_t z;
    logic  neg;
  } lane_t;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][30:0] scale;
  } side_t;

  typedef struct packed {
    logic            vld;
    lane_t [2:0]     lane;
    side_t           side;
  } cell_t;

  typedef struct packed {
    logic                    vld;
    logic [8:0][63:0]        prod;
    side_t                   side;
  } mat_t;

  function automatic zval_t atan_q28(input logic [4:0] idx);
    zval_t v;
    case (idx)
      5'd0:  v = 33'sd210828714;
      5'd1:  v = 33'sd124459457;
      5'd2:  v = 33'sd65760959;
      5'd3:  v = 33'sd33381290;
      5'd4:  v = 33'sd16755422;
      5'd5:  v = 33'sd8385879;
      5'd6:  v = 33'sd4193963;
      5'd7:  v = 33'sd2097109;
      5'd8:  v = 33'sd1048571;
      5'd9:  v = 33'sd524287;
      5'd10: v = 33'sd262144;
      5'd11: v = 33'sd131072;
      5'd12: v = 33'sd65536;
      5'd13: v = 33'sd32768;
      5'd14: v = 33'sd16384;
      5'd15: v = 33'sd8192;
      5'd16: v = 33'sd4096;
      5'd17: v = 33'sd2048;
      5'd18: v = 33'sd1024;
      5'd19: v = 33'sd512;
      5'd20: v = 33'sd256;
      5'd21: v = 33'sd128;
      5'd22: v = 33'sd64;
      5'd23: v = 33'sd32;
      default: v = 33'sd0;
    endcase
    return v;
  endfunction

  // Q2.30 product rounded half up with a floor shift.
  function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sd536870912;
    return 32'(p >>> 30);
  endfunction

endpackage

// ===== rtl/trs_cordic_cell.sv =====
// One rotation-mode CORDIC step for the three angle lanes of a pose.
module trs_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  trs_pkg::cell_t d,
  output trs_pkg::cell_t q
);

  trs_pkg::cell_t q_r, q_nxt;

  always_comb begin
    trs_pkg::cval_t dx;
    trs_pkg::cval_t dy;
    trs_pkg::zval_t at;
    q_nxt = d;
    at = trs_pkg::atan_q28(5'(STEP));
    for (int k = 0; k < 3; k++) begin
      dx = d.lane[k].y >>> STEP;
      dy = d.lane[k].x >>> STEP;
      if (!d.lane[k].z[32]) begin
        q_nxt.lane[k].x = d.lane[k].x - dx;
        q_nxt.lane[k].y = d.lane[k].y + dy;
        q_nxt.lane[k].z = d.lane[k].z - at;
      end else begin
        q_nxt.lane[k].x = d.lane[k].x + dx;
        q_nxt.lane[k].y = d.lane[k].y - dy;
        q_nxt.lane[k].z = d.lane[k].z + at;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

// ===== rtl/trs_matrix.sv =====
// Rotation products and per-column scale products, four pipeline stages.
module trs_matrix (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  trs_pkg::cell_t d,
  output trs_pkg::mat_t  q
);

  typedef logic signed [31:0] s32_t;
  typedef logic signed [32:0] s33_t;

  // The z sine and cosine are needed one stage later; they ride along here.
  typedef struct packed {
    logic  vld;
    s32_t  cycz, cysz, cxsz, sxsy, cxcz, sxcy, sxsz, cxsy, sxcz, cxcy, sy;
    s32_t  cz, sz;
    trs_pkg::side_t side;
  } m1_t;

  typedef struct packed {
    logic  vld;
    s32_t  cycz, cysz, cxsz, cxcz, sxcy, sxsz, sxcz, cxcy, sy;
    s32_t  sxsycz, sxsysz, cxsycz, cxsysz;
    trs_pkg::side_t side;
  } m2_t;

  typedef struct packed {
    logic            vld;
    logic [8:0][32:0] r;
    trs_pkg::side_t  side;
  } rm_t;

  m1_t m1_r, m1_nxt;
  m2_t m2_r, m2_nxt;
  rm_t rm_r, rm_nxt;
  trs_pkg::mat_t p_r, p_nxt;

  s32_t sn [3];
  s32_t cs [3];

  // Undo the half-turn fold and drop the headroom bits.
  always_comb begin
    trs_pkg::cval_t ys;
    trs_pkg::cval_t xs;
    for (int k = 0; k < 3; k++) begin
      ys = d.lane[k].neg ? -d.lane[k].y : d.lane[k].y;
      xs = d.lane[k].neg ? -d.lane[k].x : d.lane[k].x;
      sn[k] = ys[31:0];
      cs[k] = xs[31:0];
    end
  end

  always_comb begin
    m1_nxt.vld  = d.vld;
    m1_nxt.side = d.side;
    m1_nxt.cycz = trs_pkg::mul_q30(cs[1], cs[2]);
    m1_nxt.cysz = trs_pkg::mul_q30(cs[1], sn[2]);
    m1_nxt.cxsz = trs_pkg::mul_q30(cs[0], sn[2]);
    m1_nxt.sxsy = trs_pkg::mul_q30(sn[0], sn[1]);
    m1_nxt.cxcz = trs_pkg::mul_q30(cs[0], cs[2]);
    m1_nxt.sxcy = trs_pkg::mul_q30(sn[0], cs[1]);
    m1_nxt.sxsz = trs_pkg::mul_q30(sn[0], sn[2]);
    m1_nxt.cxsy = trs_pkg::mul_q30(cs[0], sn[1]);
    m1_nxt.sxcz = trs_pkg::mul_q30(sn[0], cs[2]);
    m1_nxt.cxcy = trs_pkg::mul_q30(cs[0], cs[1]);
    m1_nxt.sy   = sn[1];
    m1_nxt.cz   = cs[2];
    m1_nxt.sz   = sn[2];
  end

  always_comb begin
    m2_nxt.vld    = m1_r.vld;
    m2_nxt.side   = m1_r.side;
    m2_nxt.cycz   = m1_r.cycz;
    m2_nxt.cysz   = m1_r.cysz;
    m2_nxt.cxsz   = m1_r.cxsz;
    m2_nxt.cxcz   = m1_r.cxcz;
    m2_nxt.sxcy   = m1_r.sxcy;
    m2_nxt.sxsz   = m1_r.sxsz;
    m2_nxt.sxcz   = m1_r.sxcz;
    m2_nxt.cxcy   = m1_r.cxcy;
    m2_nxt.sy     = m1_r.sy;
    m2_nxt.sxsycz = trs_pkg::mul_q30(m1_r.sxsy, m1_r.cz);
    m2_nxt.sxsysz = trs_pkg::mul_q30(m1_r.sxsy, m1_r.sz);
    m2_nxt.cxsycz = trs_pkg::mul_q30(m1_r.cxsy, m1_r.cz);
    m2_nxt.cxsysz = trs_pkg::mul_q30(m1_r.cxsy, m1_r.sz);
  end

  always_comb begin
    rm_nxt.vld  = m2_r.vld;
    rm_nxt.side = m2_r.side;
    rm_nxt.r[0] = 33'(m2_r.cycz);
    rm_nxt.r[1] = -33'(m2_r.cysz);
    rm_nxt.r[2] = 33'(m2_r.sy);
    rm_nxt.r[3] = 33'(m2_r.cxsz) + 33'(m2_r.sxsycz);
    rm_nxt.r[4] = 33'(m2_r.cxcz) - 33'(m2_r.sxsysz);
    rm_nxt.r[5] = -33'(m2_r.sxcy);
    rm_nxt.r[6] = 33'(m2_r.sxsz) - 33'(m2_r.cxsycz);
    rm_nxt.r[7] = 33'(m2_r.sxcz) + 33'(m2_r.cxsysz);
    rm_nxt.r[8] = 33'(m2_r.cxcy);
  end

  always_comb begin
    s33_t rv;
    logic signed [31:0] sc;
    p_nxt.vld  = rm_r.vld;
    p_nxt.side = rm_r.side;
    for (int e = 0; e < 9; e++) begin
      rv = rm_r.r[e];
      sc = {1'b0, rm_r.side.scale[e % 3]};
      p_nxt.prod[e] = 64'(rv) * 64'(sc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_r.vld <= 1'b0;
      m2_r.vld <= 1'b0;
      rm_r.vld <= 1'b0;
      p_r.vld  <= 1'b0;
    end else if (en) begin
      m1_r <= m1_nxt;
      m2_r <= m2_nxt;
      rm_r <= rm_nxt;
      p_r  <= p_nxt;
    end
  end

  assign q = p_r;

endmodule

// ===== rtl/trs_model_matrix_builder.sv =====
// Top level of the pose to model matrix builder (T * Rx * Ry * Rz * S).
//
//   Channel  Dir  Beat contents
//   in_      in   pos_x/y/z, angle_x/y/z, scale_x/y/z packed in in_tdata
//   out_     out  m00..m22, trans_x/y/z packed in out_tdata
//
// One pose is accepted per cycle while the output is not stalled; each result
// passes through the angle preparation register, the chain of CORDIC cells, one
// cell per rotation step, the multiplier stages and the output register.
// Reset (rst_n low, synchronous) clears only the valid bits of the pipeline.
// A stalled output freezes the whole pipeline; input is taken again as soon
// as the output register is empty or is being read in the same cycle.
module trs_model_matrix_builder #(
  parameter int CORDIC_STEPS = trs_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // pos_x[31:0], pos_y[63:32], pos_z[95:64], angle_x[111:96], angle_y[127:112],
  // angle_z[143:128], scale_x[174:144], scale_y[205:175], scale_z[236:206]
  input  logic [trs_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22, trans_x, trans_y, trans_z,
  // 32 bits each from bit 0 up
  output logic [trs_pkg::OUT_DATA_W-1:0]  out_tdata
);

  logic                           out_valid_r;
  logic [trs_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // The pipeline advances whenever the output register can take a beat.
  logic en;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // Angle reduction and fold into [-pi/2, pi/2], then the start vector.
  trs_pkg::cell_t prep_r, prep_nxt;

  always_comb begin
    trs_pkg::zval_t a;
    logic [15:0] ang;
    prep_nxt            = '0;
    prep_nxt.vld        = in_tvalid;
    prep_nxt.side.pos[0]   = in_tdata[31:0];
    prep_nxt.side.pos[1]   = in_tdata[63:32];
    prep_nxt.side.pos[2]   = in_tdata[95:64];
    prep_nxt.side.scale[0] = in_tdata[174:144];
    prep_nxt.side.scale[1] = in_tdata[205:175];
    prep_nxt.side.scale[2] = in_tdata[236:206];
    for (int k = 0; k < 3; k++) begin
      ang = in_tdata[96 + 16*k +: 16];
      a = {ang[15], ang, 16'h0000};
      // A 16-bit angle is within one turn of the principal range.
      if (a > trs_pkg::PI_Q28) begin
        a = a - trs_pkg::TWO_PI_Q28;
      end else if (a < -trs_pkg::PI_Q28) begin
        a = a + trs_pkg::TWO_PI_Q28;
      end
      prep_nxt.lane[k].neg = 1'b0;
      if (a > trs_pkg::HALF_PI_Q28) begin
        a = a - trs_pkg::PI_Q28;
        prep_nxt.lane[k].neg = 1'b1;
      end else if (a < -trs_pkg::HALF_PI_Q28) begin
        a = a + trs_pkg::PI_Q28;
        prep_nxt.lane[k].neg = 1'b1;
      end
      prep_nxt.lane[k].x = trs_pkg::GAIN_Q30;
      prep_nxt.lane[k].y = '0;
      prep_nxt.lane[k].z = a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_r.vld <= 1'b0;
    end else if (en) begin
      prep_r <= prep_nxt;
    end
  end

  // Chain of CORDIC cells, one rotation step each.
  trs_pkg::cell_t chain [CORDIC_STEPS+1];
  assign chain[0] = prep_r;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    trs_cordic_cell #(.STEP(i)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d     (chain[i]),
      .q     (chain[i+1])
    );
  end

  trs_pkg::mat_t mat;

  trs_matrix u_matrix (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .d     (chain[CORDIC_STEPS]),
    .q     (mat)
  );

  // Final rounding to Q16.16 with saturation, then the output register.
  always_comb begin
    logic signed [63:0] v;
    for (int e = 0; e < 9; e++) begin
      v = (signed'(mat.prod[e]) + 64'sd536870912) >>> 30;
      if (v > 64'sd2147483647) begin
        out_data_nxt[32*e +: 32] = 32'h7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
        out_data_nxt[32*e +: 32] = 32'h8000_0000;
      end else begin
        out_data_nxt[32*e +: 32] = v[31:0];
      end
    end
    out_data_nxt[288 +: 32] = mat.side.pos[0];
    out_data_nxt[320 +: 32] = mat.side.pos[1];
    out_data_nxt[352 +: 32] = mat.side.pos[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= mat.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the pose to model matrix builder.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS = trs_pkg::CORDIC_STEPS_DEF;
  localparam int LATENCY = STEPS + 5;
  localparam int N_RANDOM = 620;

  // One pose and one matrix, typed at the widths of the ports.
  typedef struct packed {
    logic [30:0] scl_z, scl_y, scl_x;
    logic signed [15:0] ang_z, ang_y, ang_x;
    logic signed [31:0] pz, py, px;
  } pose_t;

  typedef struct {
    logic [31:0] m [12];
  } matrix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [trs_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [trs_pkg::OUT_DATA_W-1:0] out_tdata;

  always #5 clk = ~clk;

  trs_model_matrix_builder #(.CORDIC_STEPS(STEPS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  matrix_t pending_matrices[$];
  int mismatches = 0;
  int beats_in = 0;
  int beats_out = 0;
  bit sender_done = 1'b0;
  bit hold_sink = 1'b0;

  // Arctangent table of the rotation steps, Q3.28.
  const longint atan_tab [24] = '{
    210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963,
    2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128, 64, 32};

  // Arithmetic right shift on 64-bit values rounds toward minus infinity.
  function automatic longint fix_mul(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // Range reduction, half-turn fold and CORDIC rotation of one angle.
  function automatic void angle_sincos(input logic signed [15:0] ang,
                                       output longint sn, output longint cs);
    longint z, x, y, t;
    bit flip;
    z = longint'(ang) * 65536;
    x = 652032874;
    y = 0;
    flip = 1'b0;
    while (z > 843314857) z -= 1686629713;
    while (z < -843314857) z += 1686629713;
    if (z > 421657428) begin
      z -= 843314857;
      flip = 1'b1;
    end else if (z < -421657428) begin
      z += 843314857;
      flip = 1'b1;
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_tab[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_tab[i];
      end
      x = t;
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endfunction

  function automatic matrix_t build_model_matrix(pose_t p);
    matrix_t res;
    longint sx, cx, sy, cy, sz, cz, v;
    longint rot [9];
    longint scl [3];
    angle_sincos(p.ang_x, sx, cx);
    angle_sincos(p.ang_y, sy, cy);
    angle_sincos(p.ang_z, sz, cz);
    rot[0] = fix_mul(cy, cz);
    rot[1] = -fix_mul(cy, sz);
    rot[2] = sy;
    rot[3] = fix_mul(cx, sz) + fix_mul(fix_mul(sx, sy), cz);
    rot[4] = fix_mul(cx, cz) - fix_mul(fix_mul(sx, sy), sz);
    rot[5] = -fix_mul(sx, cy);
    rot[6] = fix_mul(sx, sz) - fix_mul(fix_mul(cx, sy), cz);
    rot[7] = fix_mul(sx, cz) + fix_mul(fix_mul(cx, sy), sz);
    rot[8] = fix_mul(cx, cy);
    scl[0] = longint'(p.scl_x);
    scl[1] = longint'(p.scl_y);
    scl[2] = longint'(p.scl_z);
    for (int k = 0; k < 9; k++) begin
      v = fix_mul(rot[k], scl[k % 3]);
      // Each entry saturates to the signed 32-bit range.
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      res.m[k] = v[31:0];
    end
    res.m[9] = p.px;
    res.m[10] = p.py;
    res.m[11] = p.pz;
    return res;
  endfunction

  task automatic report_mismatch(string what, int idx, logic [31:0] got,
                                 logic [31:0] want);
    mismatches++;
    $display("MISMATCH beat %0d %s[%0d]: got %h expected %h", beats_out, what,
             idx, got, want);
  endtask

  // Directed rows: angles at zero, the folds and the extremes, scale at zero
  // and full range, positions at the extremes. With zero angles and unit
  // scale the expected diagonal is the cosine gain result, so every row is
  // checked against the predictor.
  localparam int N_DIRECTED = 14;
  logic [95:0] dir_ang [N_DIRECTED] = '{
    {16'sd0, 16'sd0, 16'sd0, 48'd0},
    {16'sd6434, 16'sd0, 16'sd0, 48'd0},
    {16'sd0, 16'sd6434, 16'sd0, 48'd0},
    {16'sd0, 16'sd0, 16'sd6434, 48'd0},
    {16'sd12868, 16'sd12868, 16'sd12868, 48'd0},
    {-16'sd12868, -16'sd12868, -16'sd12868, 48'd0},
    {16'sd6436, -16'sd6436, 16'sd6437, 48'd0},
    {16'sh7fff, 16'sh7fff, 16'sh7fff, 48'd0},
    {16'sh8000, 16'sh8000, 16'sh8000, 48'd0},
    {16'sh8000, 16'sh7fff, 16'sd0, 48'd0},
    {16'sd3217, -16'sd3217, 16'sd25736, 48'd0},
    {16'sd12869, -16'sd12869, 16'sd1, 48'd0},
    {-16'sd1, 16'sd1, -16'sd6433, 48'd0},
    {16'sd0, 16'sd0, 16'sd0, 48'd0}};
  logic [30:0] dir_scale [N_DIRECTED] = '{
    31'h10000, 31'h10000, 31'h10000, 31'h10000, 31'h7fffffff, 31'h7fffffff,
    31'h0, 31'h7fffffff, 31'h7fffffff, 31'h10000, 31'h3, 31'h7fff0000,
    31'h1, 31'h0};
  logic [31:0] dir_pos [N_DIRECTED] = '{
    32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h00010000,
    32'h55555555, 32'haaaaaaaa, 32'h7fffffff, 32'h80000000, 32'h1,
    32'hfffe0000, 32'h12345678, 32'h0, 32'hdeadbeef};

  // Sends one pose, idling for a random gap first; tvalid stays high across
  // back to back beats.
  task automatic send_pose(pose_t p, int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {3'b000, p};
    pending_matrices.push_back(build_model_matrix(p));
    do @(posedge clk); while (!in_tready);
    beats_in++;
  endtask

  function automatic logic [30:0] rand_scale();
    case ($urandom_range(0, 5))
      0: return 31'($urandom);
      1: return 31'($urandom_range(0, 32'h40000));
      2: return 31'h7fffffff;
      3: return '0;
      default: return 31'($urandom_range(0, 32'h30000));
    endcase
  endfunction

  function automatic pose_t rand_pose();
    pose_t p;
    p.px = $urandom;
    p.py = $urandom;
    p.pz = $urandom;
    p.ang_x = 16'($urandom);
    p.ang_y = 16'($urandom);
    p.ang_z = 16'($urandom);
    p.scl_x = rand_scale();
    p.scl_y = rand_scale();
    p.scl_z = rand_scale();
    return p;
  endfunction

  // Stimulus: reset, directed rows, a burst against a stalled sink, a pause
  // until the block drains, then random poses with random gaps.
  initial begin
    pose_t p;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int r = 0; r < N_DIRECTED; r++) begin
      {p.ang_z, p.ang_y, p.ang_x} = dir_ang[r][95:48];
      p.scl_x = dir_scale[r];
      p.scl_y = dir_scale[(r + 3) % N_DIRECTED];
      p.scl_z = dir_scale[(r + 7) % N_DIRECTED];
      p.px = dir_pos[r];
      p.py = ~dir_pos[r];
      p.pz = dir_pos[(r + 5) % N_DIRECTED];
      send_pose(p, $urandom_range(0, 2));
    end
    // Hold the sink for a long stretch and keep offering back to back.
    hold_sink = 1'b1;
    for (int k = 0; k < 3 * LATENCY; k++) send_pose(rand_pose(), 0);
    in_tvalid <= 1'b0;
    wait (pending_matrices.size() == 0);
    for (int k = 0; k < N_RANDOM; k++)
      send_pose(rand_pose(), ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0);
    in_tvalid <= 1'b0;
    sender_done = 1'b1;
  end

  // Sink: random stalls, plus one long hold-off that it counts itself and then
  // releases.
  initial begin
    int stall;
    int held;
    forever begin
      @(posedge clk);
      if (hold_sink) begin
        out_tready <= 1'b0;
        held = 0;
        while (held < 8 * LATENCY) begin
          @(posedge clk);
          held++;
        end
        hold_sink = 1'b0;
      end
      stall = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 13) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      // The beat lands here; the monitor checks it in the same step.
    end
  end

  // Checks every output beat against the oldest expected matrix.
  always @(posedge clk) begin
    matrix_t want;
    if (rst_n && out_tvalid && out_tready) begin
      beats_out++;
      if (pending_matrices.size() == 0) begin
        report_mismatch("unexpected", 0, out_tdata[31:0], '0);
      end else begin
        want = pending_matrices.pop_front();
        for (int k = 0; k < 12; k++)
          if (out_tdata[32*k +: 32] !== want.m[k])
            report_mismatch(k < 9 ? "m" : "trans", k, out_tdata[32*k +: 32],
                            want.m[k]);
      end
    end
  end

  initial begin
    wait (sender_done && pending_matrices.size() == 0);
    repeat (4 * LATENCY) @(posedge clk);
    $display("Covered %0d poses in, %0d matrices out: angle folds, extremes,",
             beats_in, beats_out);
    $display("zero and full-range scales, back-pressure and random gaps.");
    if (mismatches == 0 && pending_matrices.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
